FILE: design/bmam_pkg.sv
// Package: request and response types, mapper state types and codes shared by the mapper.
`timescale 1ns / 1ps

package bmam_pkg;

   // Request operation codes.
   typedef enum logic [1:0] {
      OP_BUS_READ  = 2'd0,
      OP_BUS_WRITE = 2'd1,
      OP_PORT_A    = 2'd2,
      OP_NONE      = 2'd3
   } op_type;

   // Banking mode codes held in the mode register.
   typedef enum logic [1:0] {
      MODE_PLAIN    = 2'd0,
      MODE_PAGED    = 2'd1,
      MODE_HIGH_MMU = 2'd2,
      MODE_FLAT     = 2'd3
   } mode_type;

   // Response action codes.
   typedef enum logic [2:0] {
      ACT_MEM_READ  = 3'd0,
      ACT_MEM_WRITE = 3'd1,
      ACT_ROM_DROP  = 3'd2,
      ACT_PORT_READ = 3'd3,
      ACT_PORT_FWD  = 3'd4,
      ACT_REG_WRITE = 3'd5,
      ACT_DEBUG_FF  = 3'd6,
      ACT_NONE      = 3'd7
   } action_type;

   // Address decode constants.
   localparam logic [7:0]  IO_PAGE          = 8'hFE;
   localparam logic [15:0] HIGH_MMU_SPLIT   = 16'hE000;
   localparam logic [15:0] PLAIN_RAM_LIMIT  = 16'h8000;
   localparam logic [5:0]  PAGED_RAM_FIRST  = 6'd32;

   // Mapper port numbers inside the I/O page.
   localparam logic [7:0]  PORT_HIGH_MMU    = 8'hFF;
   localparam logic [7:0]  PORT_PROT_LOW    = 8'hFC;
   localparam logic [7:0]  PORT_PROT_HIGH   = 8'hFB;
   localparam logic [7:0]  PORT_BANK_FIRST  = 8'h78;
   localparam logic [7:0]  PORT_BANK_LAST   = 8'h7B;
   localparam logic [7:0]  PORT_ENABLE_FIRST = 8'h7C;
   localparam logic [7:0]  PORT_ENABLE_LAST = 8'h7F;

   localparam logic [7:0]  DEBUG_READ_VALUE = 8'hFF;
   localparam logic [7:0]  PA3_CLEAR_MASK   = 8'hF7;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] address;
      logic [7:0]  write_value;
      logic        debug_read;
      logic [7:0]  port_a_data;
      logic        pa3_is_output;
   } req_type;

   typedef struct packed {
      logic [19:0] phys_address;
      logic [2:0]  action;
      logic [7:0]  port_address;
      logic [7:0]  out_value;
      logic        protection_fault;
   } rsp_type;

   // Mapper registers other than the mode.
   typedef struct packed {
      logic [3:0][5:0] bank_page;
      logic            banking_on;
      logic [7:0]      high_mmu_reg;
      logic [7:0]      protect_low_page;
      logic [7:0]      protect_high_page;
      logic [3:0]      flat_page;
   } map_state_type;

   // Register loads caused by one request.
   typedef struct packed {
      logic       wr_high_mmu;
      logic       wr_bank;
      logic [1:0] bank_index;
      logic       wr_banking;
      logic       wr_prot_low;
      logic       wr_prot_high;
      logic       wr_flat;
      logic [7:0] value;
      logic [3:0] flat_value;
   } map_update_type;

endpackage

FILE: design/bmam_translate.sv
// Combinational translation of one request into a response and mapper register loads.
`timescale 1ns / 1ps

module bmam_translate
   import bmam_pkg::*;
(
   input  req_type        req,
   input  mode_type       bank_mode,
   input  map_state_type  state,
   output rsp_type        rsp,
   output map_update_type update
);

   logic        io_page;
   logic [7:0]  port;
   logic [7:0]  mmu_bits;
   logic [3:0]  high_page;
   logic [5:0]  paged_page;
   logic [19:0] mapped_address;
   logic        writable;
   logic        fault;
   logic [7:0]  pa_bits;
   logic        port_taken;

   assign io_page = (req.address[15:8] == IO_PAGE);
   assign port    = req.address[7:0];

   // High MMU register: the low window uses the register shifted right by one.
   assign mmu_bits   = (req.address < HIGH_MMU_SPLIT) ? {1'b0, state.high_mmu_reg[7:1]}
                                                      : state.high_mmu_reg;
   assign high_page  = {mmu_bits[0], mmu_bits[2], mmu_bits[4], mmu_bits[6]};
   assign paged_page = state.bank_page[req.address[15:14]];

   always_comb begin
      mapped_address = {4'd0, req.address};
      writable       = 1'b0;
      unique case (bank_mode)
         MODE_HIGH_MMU: begin
            mapped_address = {high_page, req.address};
            writable       = high_page[3];
         end
         MODE_PAGED: begin
            if (state.banking_on) begin
               mapped_address = {paged_page, req.address[13:0]};
               writable       = (paged_page >= PAGED_RAM_FIRST);
            end
         end
         MODE_FLAT: begin
            mapped_address = {state.flat_page, req.address};
            writable       = state.flat_page[3];
         end
         MODE_PLAIN: begin
            writable = (req.address < PLAIN_RAM_LIMIT);
         end
         default: begin
            writable = 1'b0;
         end
      endcase
   end

   assign fault = (state.protect_low_page != 8'd0) &&
                  (req.address[15:8] >= state.protect_low_page) &&
                  (req.address[15:8] < state.protect_high_page);

   assign pa_bits = req.pa3_is_output ? req.port_a_data : (req.port_a_data & PA3_CLEAR_MASK);

   // Port write decode: which mapper register, if any, takes the byte.
   always_comb begin
      update            = '0;
      update.value      = req.write_value;
      update.bank_index = port[1:0];
      update.flat_value = {pa_bits[3], pa_bits[4], pa_bits[5], pa_bits[6]};
      port_taken        = 1'b0;
      if (port == PORT_HIGH_MMU && bank_mode == MODE_HIGH_MMU) begin
         update.wr_high_mmu = 1'b1;
         port_taken         = 1'b1;
      end else if (bank_mode == MODE_PAGED && port >= PORT_BANK_FIRST &&
                   port <= PORT_BANK_LAST) begin
         update.wr_bank = 1'b1;
         port_taken     = 1'b1;
      end else if (bank_mode == MODE_PAGED && port >= PORT_ENABLE_FIRST &&
                   port <= PORT_ENABLE_LAST) begin
         update.wr_banking = 1'b1;
         port_taken        = 1'b1;
      end else if (port == PORT_PROT_LOW) begin
         update.wr_prot_low = 1'b1;
         port_taken         = 1'b1;
      end else if (port == PORT_PROT_HIGH) begin
         update.wr_prot_high = 1'b1;
         port_taken          = 1'b1;
      end

      // Only an I/O page write or a port A update actually loads anything.
      if (!(req.operation == OP_BUS_WRITE && io_page)) begin
         update.wr_high_mmu  = 1'b0;
         update.wr_bank      = 1'b0;
         update.wr_banking   = 1'b0;
         update.wr_prot_low  = 1'b0;
         update.wr_prot_high = 1'b0;
      end
      update.wr_flat = (req.operation == OP_PORT_A);
   end

   always_comb begin
      rsp = '0;
      rsp.action = ACT_NONE;
      unique case (op_type'(req.operation))
         OP_BUS_READ: begin
            if (io_page) begin
               rsp.port_address = port;
               if (req.debug_read) begin
                  rsp.action    = ACT_DEBUG_FF;
                  rsp.out_value = DEBUG_READ_VALUE;
               end else begin
                  rsp.action = ACT_PORT_READ;
               end
            end else begin
               rsp.phys_address = mapped_address;
               rsp.action       = ACT_MEM_READ;
            end
         end
         OP_BUS_WRITE: begin
            rsp.out_value = req.write_value;
            if (io_page) begin
               rsp.port_address = port;
               rsp.action       = port_taken ? ACT_REG_WRITE : ACT_PORT_FWD;
            end else begin
               rsp.phys_address     = mapped_address;
               rsp.protection_fault = fault;
               rsp.action           = writable ? ACT_MEM_WRITE : ACT_ROM_DROP;
            end
         end
         OP_PORT_A, OP_NONE: begin
            rsp.action = ACT_NONE;
         end
         default: begin
            rsp.action = ACT_NONE;
         end
      endcase
   end

endmodule

FILE: design/bmam_state.sv
// Mapper registers: banking mode, bank pages, MMU, protection window and flat page.
`timescale 1ns / 1ps

module bmam_state
   import bmam_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_wr_en,
   input  logic [1:0]     csr_wr_data,
   input  logic           update_en,
   input  map_update_type update,
   output mode_type       bank_mode,
   output map_state_type  state
);

   mode_type      mode_ff, mode_in;
   map_state_type state_ff, state_in;

   always_comb begin
      mode_in  = mode_ff;
      state_in = state_ff;
      if (csr_wr_en) begin
         // A mode write also reloads the banking enable for that mode.
         mode_in             = mode_type'(csr_wr_data);
         state_in.banking_on = (mode_in == MODE_PAGED) || (mode_in == MODE_HIGH_MMU);
      end else if (update_en) begin
         if (update.wr_high_mmu) begin
            state_in.high_mmu_reg = update.value;
         end
         if (update.wr_bank) begin
            state_in.bank_page[update.bank_index] = update.value[5:0];
         end
         if (update.wr_banking) begin
            state_in.banking_on = update.value[0];
         end
         if (update.wr_prot_low) begin
            state_in.protect_low_page = update.value;
         end
         if (update.wr_prot_high) begin
            state_in.protect_high_page = update.value;
         end
         if (update.wr_flat) begin
            state_in.flat_page = update.flat_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_PLAIN;
         state_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         state_ff <= state_in;
      end
   end

   assign bank_mode = mode_ff;
   assign state     = state_ff;

endmodule

FILE: design/banked_memory_address_mapper.sv
// Top level: request register, address translation, mapper registers and response register.
`timescale 1ns / 1ps
// Throughput: one request per cycle while rsp_stall does not hold the response register;
// the request register feeds the translation logic, which reads and updates the mapper
// registers in the same cycle it loads the response.
// Reset clears both pipeline valids, the mode (plain) and every mapper register to zero.

module banked_memory_address_mapper
   import bmam_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_payload,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data
);

   // Request register stage.
   logic    req_valid_ff, req_valid_in;
   req_type req_data_ff, req_data_in;

   // Response register stage.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic           req_accept;
   logic           advance;
   mode_type       bank_mode;
   map_state_type  map_state;
   rsp_type        translated;
   map_update_type update;

   // The response register can take a new result when it is empty or being drained.
   // The request register only stalls when its request cannot move forward.
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = req_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      req_valid_in = req_valid_ff;
      req_data_in  = req_data_ff;
      if (req_accept) begin
         req_valid_in = 1'b1;
         req_data_in  = req_payload;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = req_valid_ff;
         rsp_data_in  = translated;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_data_ff <= req_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Translation sees the mapper registers as left by the previous request, so a
   // register write is in effect for the very next request.
   bmam_translate u_translate (
      .req       (req_data_ff),
      .bank_mode (bank_mode),
      .state     (map_state),
      .rsp       (translated),
      .update    (update)
   );

   // Registers are loaded as the request moves into the response register.
   bmam_state u_state (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .update_en   (req_valid_ff && advance),
      .update      (update),
      .bank_mode   (bank_mode),
      .state       (map_state)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

FILE: design/bmam_checker.sv
// Port checker for the mapper and its bind to the top level.
`timescale 1ns / 1ps

module bmam_checker
   import bmam_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input rsp_type    rsp_payload
);

   // A stalled response stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response does not change.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_payload))
      else $error("response changed while stalled");

   // With the output empty, requests are never held off.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output");

   // Reset leaves no response pending.
   assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response valid after reset");

   // A protection fault only comes with a memory write.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.protection_fault |->
         (rsp_payload.action == ACT_MEM_WRITE) || (rsp_payload.action == ACT_ROM_DROP))
      else $error("fault flagged on a non-write");

endmodule

bind banked_memory_address_mapper bmam_checker u_checker (.*);

FILE: sim/bmam_response_monitor.sv
// Response monitor: predicts every mapper response from the accepted requests and compares it.
`timescale 1ns / 1ps

module bmam_response_monitor
   import bmam_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  req_type    req_payload,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  rsp_type    rsp_payload,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data,
   output int         mismatch_count,
   output int         outstanding,
   output int         responses_checked,
   output int         fault_responses
);

   // Shadow copy of the mapper registers.
   mode_type   mode;
   logic [5:0] bank_page [4];
   logic       banking_on;
   logic [7:0] high_mmu_reg;
   logic [7:0] protect_low_page;
   logic [7:0] protect_high_page;
   logic [3:0] flat_page;

   rsp_type    expected_responses [$];

   function automatic logic [19:0] translate_address(input logic [15:0] addr,
                                                     output logic writable);
      logic [7:0] r;
      logic [3:0] page;
      logic [5:0] bank;
      if (mode == MODE_HIGH_MMU) begin
         r = (addr < HIGH_MMU_SPLIT) ? (high_mmu_reg >> 1) : high_mmu_reg;
         page = {r[0], r[2], r[4], r[6]};
         writable = page[3];
         return {page, addr};
      end
      if (mode == MODE_PAGED && banking_on) begin
         bank = bank_page[addr[15:14]];
         writable = (bank >= PAGED_RAM_FIRST);
         return {bank, addr[13:0]};
      end
      if (mode == MODE_FLAT) begin
         writable = flat_page[3];
         return {flat_page, addr};
      end
      writable = (mode == MODE_PLAIN) && (addr < PLAIN_RAM_LIMIT);
      return {4'h0, addr};
   endfunction

   // Returns 1 when the port write lands in a mapper register.
   function automatic bit load_mapper_port(input logic [7:0] port, input logic [7:0] value);
      if (port == PORT_HIGH_MMU && mode == MODE_HIGH_MMU) begin
         high_mmu_reg = value;
         return 1'b1;
      end
      if (mode == MODE_PAGED && port >= PORT_BANK_FIRST && port <= PORT_BANK_LAST) begin
         bank_page[port[1:0]] = value[5:0];
         return 1'b1;
      end
      if (mode == MODE_PAGED && port >= PORT_ENABLE_FIRST && port <= PORT_ENABLE_LAST) begin
         banking_on = value[0];
         return 1'b1;
      end
      if (port == PORT_PROT_LOW) begin
         protect_low_page = value;
         return 1'b1;
      end
      if (port == PORT_PROT_HIGH) begin
         protect_high_page = value;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic rsp_type map_request(input req_type r);
      rsp_type    res;
      logic       writable;
      logic       io_page;
      logic [7:0] bits;
      res = '0;
      res.action = ACT_NONE;
      io_page = (r.address[15:8] == IO_PAGE);
      case (op_type'(r.operation))
         OP_BUS_READ: begin
            if (io_page) begin
               res.port_address = r.address[7:0];
               if (r.debug_read) begin
                  res.action = ACT_DEBUG_FF;
                  res.out_value = DEBUG_READ_VALUE;
               end else begin
                  res.action = ACT_PORT_READ;
               end
            end else begin
               res.phys_address = translate_address(r.address, writable);
               res.action = ACT_MEM_READ;
            end
         end
         OP_BUS_WRITE: begin
            res.out_value = r.write_value;
            if (io_page) begin
               res.port_address = r.address[7:0];
               res.action = load_mapper_port(r.address[7:0], r.write_value) ?
                            ACT_REG_WRITE : ACT_PORT_FWD;
            end else begin
               res.protection_fault = (protect_low_page != 8'h00) &&
                                      (r.address[15:8] >= protect_low_page) &&
                                      (r.address[15:8] < protect_high_page);
               res.phys_address = translate_address(r.address, writable);
               res.action = writable ? ACT_MEM_WRITE : ACT_ROM_DROP;
            end
         end
         OP_PORT_A: begin
            bits = r.port_a_data;
            if (!r.pa3_is_output)
               bits &= PA3_CLEAR_MASK;
            flat_page = {bits[3], bits[4], bits[5], bits[6]};
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [19:0] want,
                                       input logic [19:0] got);
      if (got !== want) begin
         $error("%s expected %h actual %h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         mode = MODE_PLAIN;
         for (int i = 0; i < 4; i++)
            bank_page[i] = '0;
         banking_on = 1'b0;
         high_mmu_reg = '0;
         protect_low_page = '0;
         protect_high_page = '0;
         flat_page = '0;
         expected_responses.delete();
      end else begin
         if (csr_wr_en === 1'b1) begin
            mode = mode_type'(csr_wr_data);
            banking_on = (mode == MODE_PAGED || mode == MODE_HIGH_MMU);
         end
         if (req_valid === 1'b1 && req_stall === 1'b0)
            expected_responses.push_back(map_request(req_payload));
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (expected_responses.size() == 0) begin
               $error("response with no request waiting for it: %h", rsp_payload);
               mismatch_count++;
            end else begin
               want = expected_responses.pop_front();
               check_field("phys_address", want.phys_address, rsp_payload.phys_address);
               check_field("action", 20'(want.action), 20'(rsp_payload.action));
               check_field("port_address", 20'(want.port_address),
                           20'(rsp_payload.port_address));
               check_field("out_value", 20'(want.out_value), 20'(rsp_payload.out_value));
               check_field("protection_fault", 20'(want.protection_fault),
                           20'(rsp_payload.protection_fault));
               responses_checked++;
               if (want.protection_fault)
                  fault_responses++;
            end
         end
      end
      outstanding = expected_responses.size();
   end

endmodule

FILE: sim/testbench.sv
// Testbench top: drives requests and mode writes into the mapper and reports the verdict.
`timescale 1ns / 1ps

module testbench;
   import bmam_pkg::*;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid;
   logic       req_stall;
   req_type    req_payload;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_payload;
   logic       csr_wr_en;
   logic [1:0] csr_wr_data;

   // When steady is set neither side inserts idle cycles.
   bit         steady = 1'b0;
   // A nonzero value asks the response side for one long hold-off of that many cycles.
   int         hold_off_cycles = 0;
   int         requests_sent = 0;

   int         mismatch_count;
   int         outstanding;
   int         responses_checked;
   int         fault_responses;

   banked_memory_address_mapper i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   bmam_response_monitor i_monitor (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_payload       (rsp_payload),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .mismatch_count    (mismatch_count),
      .outstanding       (outstanding),
      .responses_checked (responses_checked),
      .fault_responses   (fault_responses)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Offers one request after a random gap and holds it until the mapper takes it.
   // Called and returns at a falling edge; valid stays high so that a request
   // with no gap follows without a bubble.
   task automatic send_request(input req_type r);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
      requests_sent++;
   endtask

   task automatic send_fields(input op_type op, input logic [15:0] addr,
                              input logic [7:0] value, input logic dbg,
                              input logic [7:0] pa, input logic pa3);
      req_type r;
      r.operation = op;
      r.address = addr;
      r.write_value = value;
      r.debug_read = dbg;
      r.port_a_data = pa;
      r.pa3_is_output = pa3;
      send_request(r);
   endtask

   // Stops offering and waits until every predicted response has come back.
   // An extra wait then covers the response register before a mode write.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (3) @(negedge clock);
   endtask

   // Mode writes happen only while the mapper is idle.
   task automatic set_bank_mode(input mode_type m);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Addresses on the region boundaries of every mode, or anywhere at all.
   function automatic logic [15:0] pick_address();
      case ($urandom_range(0, 23))
         0:  return 16'h0000;
         1:  return 16'h3FFF;
         2:  return 16'h4000;
         3:  return 16'h7FFF;
         4:  return 16'h8000;
         5:  return 16'hBFFF;
         6:  return 16'hC000;
         7:  return 16'hDFFF;
         8:  return 16'hE000;
         9:  return 16'hFDFF;
         10: return 16'hFF00;
         11: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Mostly memory traffic, with mapper register writes that suit the current mode
   // so that the translation keeps moving, plus port traffic and some noise.
   // Every field is random first, so unused fields also carry both values.
   function automatic req_type random_request(input mode_type m);
      req_type r;
      int      pick;
      r.operation = 2'($urandom_range(0, 3));
      r.address = 16'($urandom);
      r.write_value = 8'($urandom);
      r.debug_read = 1'($urandom);
      r.port_a_data = 8'($urandom);
      r.pa3_is_output = 1'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         r.operation = OP_BUS_READ;
         r.address = pick_address();
      end else if (pick < 65) begin
         r.operation = OP_BUS_WRITE;
         r.address = pick_address();
      end else if (pick < 80) begin
         r.operation = OP_BUS_WRITE;
         case (m)
            MODE_PAGED:    r.address = {IO_PAGE, PORT_BANK_FIRST + 8'($urandom_range(0, 7))};
            MODE_HIGH_MMU: r.address = {IO_PAGE, PORT_HIGH_MMU};
            MODE_FLAT:     r.operation = OP_PORT_A;
            default:
               r.address = {IO_PAGE, $urandom_range(0, 1) ? PORT_PROT_LOW : PORT_PROT_HIGH};
         endcase
      end else if (pick < 85) begin
         r.operation = OP_BUS_WRITE;
         r.address = {IO_PAGE, $urandom_range(0, 1) ? PORT_PROT_LOW : PORT_PROT_HIGH};
      end else if (pick < 92) begin
         r.operation = $urandom_range(0, 1) ? OP_BUS_READ : OP_BUS_WRITE;
         r.address[15:8] = IO_PAGE;
      end else if (pick < 97) begin
         r.operation = OP_PORT_A;
      end else begin
         r.operation = OP_NONE;
      end
      return r;
   endfunction

   // Response side: a random stall before each response, or one long hold-off
   // when the request side asks for it, so that the mapper fills and stalls requests.
   initial begin
      int n;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_off_cycles > 0) begin
            n = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            n = steady ? 0 : $urandom_range(0, 4);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         @(negedge clock);
      end
   end

   initial begin
      mode_type mode;
      int       waited;
      req_valid = 1'b0;
      req_payload = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = MODE_PLAIN;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Plain mode after reset: RAM below 8000 is writable, ROM above drops writes.
      // The debug flag on a memory read must not matter.
      send_fields(OP_BUS_READ, 16'h0000, 8'h00, 1'b1, 8'h00, 1'b0);
      send_fields(OP_BUS_WRITE, 16'h7FFF, 8'hA5, 1'b0, 8'h00, 1'b0);
      send_fields(OP_BUS_WRITE, 16'h8000, 8'h5A, 1'b0, 8'h00, 1'b0);
      // I/O page: debug read, plain port read, forwarded write, and the high MMU
      // port, which is only a mapper register in its own mode.
      send_fields(OP_BUS_READ, 16'hFE10, 8'h00, 1'b1, 8'h00, 1'b0);
      send_fields(OP_BUS_READ, 16'hFE10, 8'h00, 1'b0, 8'h00, 1'b0);
      send_fields(OP_BUS_WRITE, 16'hFEFF, 8'h01, 1'b0, 8'h00, 1'b0);
      // Protection window 40..7F: a write at its bottom faults, one just past it does not.
      send_fields(OP_BUS_WRITE, 16'hFEFC, 8'h40, 1'b0, 8'h00, 1'b0);
      send_fields(OP_BUS_WRITE, 16'hFEFB, 8'h80, 1'b0, 8'h00, 1'b0);
      send_fields(OP_BUS_WRITE, 16'h4000, 8'hFF, 1'b0, 8'h00, 1'b0);
      send_fields(OP_BUS_WRITE, 16'h8000, 8'h00, 1'b0, 8'h00, 1'b0);
      // Port A with PA3 not driven, and the unused operation.
      send_fields(OP_PORT_A, 16'h0000, 8'h00, 1'b0, 8'hFF, 1'b0);
      send_fields(OP_NONE, 16'hFFFF, 8'hFF, 1'b1, 8'hFF, 1'b1);

      // Paged banks: the bank value is cut to 6 bits, pages from 32 up are RAM,
      // and switching banking off falls back to the plain map with writes dropped.
      wait_for_drain();
      set_bank_mode(MODE_PAGED);
      send_fields(OP_BUS_WRITE, 16'hFE78, 8'h3F, 1'b0, 8'h00, 1'b0);
      send_fields(OP_BUS_WRITE, 16'hFE79, 8'hE0, 1'b0, 8'h00, 1'b0);
      send_fields(OP_BUS_WRITE, 16'h0000, 8'h11, 1'b0, 8'h00, 1'b0);
      send_fields(OP_BUS_WRITE, 16'h7FFF, 8'h22, 1'b0, 8'h00, 1'b0);
      send_fields(OP_BUS_WRITE, 16'hFE7D, 8'hFE, 1'b0, 8'h00, 1'b0);
      send_fields(OP_BUS_WRITE, 16'h1234, 8'h33, 1'b0, 8'h00, 1'b0);

      // High MMU: the register bits picked differ above and below E000.
      wait_for_drain();
      set_bank_mode(MODE_HIGH_MMU);
      send_fields(OP_BUS_WRITE, 16'hFEFF, 8'h55, 1'b0, 8'h00, 1'b0);
      send_fields(OP_BUS_WRITE, 16'hDFFF, 8'h44, 1'b0, 8'h00, 1'b0);
      send_fields(OP_BUS_WRITE, 16'hE000, 8'h66, 1'b0, 8'h00, 1'b0);
      send_fields(OP_BUS_WRITE, 16'hFEFF, 8'hAA, 1'b0, 8'h00, 1'b0);
      send_fields(OP_BUS_READ, 16'h0000, 8'h00, 1'b0, 8'h00, 1'b0);

      // Flat paging from port A, with PA3 driven and then not driven.
      wait_for_drain();
      set_bank_mode(MODE_FLAT);
      send_fields(OP_PORT_A, 16'h0000, 8'h00, 1'b0, 8'h78, 1'b1);
      send_fields(OP_BUS_WRITE, 16'hFFFF, 8'h77, 1'b0, 8'h00, 1'b0);
      send_fields(OP_PORT_A, 16'h0000, 8'h00, 1'b0, 8'h08, 1'b0);
      send_fields(OP_BUS_WRITE, 16'h1234, 8'h88, 1'b0, 8'h00, 1'b0);

      // Random phases, each in one mode. The first four walk through every mode,
      // some phases run without idle cycles, some hold the responses off for a long
      // stretch while requests keep coming, and some pause until the mapper is empty.
      for (int phase = 0; phase < 16; phase++) begin
         mode = (phase < 4) ? mode_type'(phase) : mode_type'($urandom_range(0, 3));
         wait_for_drain();
         steady = (phase % 4 == 1);
         set_bank_mode(mode);
         for (int i = 0; i < 105; i++) begin
            if (phase % 5 == 2 && i == 20)
               hold_off_cycles = $urandom_range(40, 60);
            if (phase % 5 == 3 && i == 50)
               wait_for_drain();
            send_request(random_request(mode));
         end
      end
      steady = 1'b0;

      // Let the last responses come back, with a bound in case some never do.
      req_valid <= 1'b0;
      waited = 0;
      while (outstanding != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      repeat (8) @(negedge clock);
      if (outstanding != 0)
         $error("%0d responses never arrived", outstanding);

      $display("Run covered %0d requests in all four banking modes, with stalls, long",
               requests_sent);
      $display("response hold-offs and full drains; %0d responses compared, %0d faulting.",
               responses_checked, fault_responses);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("[banked_memory_address_mapper] OK");
      end else begin
         $display("[banked_memory_address_mapper] ERROR");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("[banked_memory_address_mapper] ERROR");
      $finish;
   end

endmodule
